FILE: rtl/core/ifmt_pkg.sv
// ============================================================================
// ifmt_pkg
// Shared types, constants and helpers of the integer to ASCII formatter.
// ============================================================================
package ifmt_pkg;

  localparam int ValueBitsDef = 32;
  localparam int InW          = 32;
  localparam int WidthW       = 4;
  localparam int InTdataW     = ((InW + WidthW + 7) / 8) * 8;
  localparam int CharW        = 7;
  localparam int OutTdataW    = ((CharW + 7) / 8) * 8;

  localparam int DecDigits    = 10;
  localparam int HexDigits    = 8;
  localparam int MaxChars     = DecDigits + 1;
  localparam int CntW         = $clog2(MaxChars + 1);
  localparam int BcdW         = 4 * DecDigits;
  localparam int StepBits     = 8;
  localparam int NumSteps     = InW / StepBits;
  localparam int NumStg       = NumSteps + 1;

  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 1;

  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChUpA   = 7'h41;
  localparam logic [CharW-1:0] ChUpX   = 7'h58;
  localparam logic [CharW-1:0] ChLoX   = 7'h78;
  localparam logic [CharW-1:0] ChMinus = 7'h2d;
  localparam logic [3:0]       NibMask = 4'hf;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHexMode     = 2'd0,
    CfgShowPrefix  = 2'd1,
    CfgUpperPrefix = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [InW-1:0]    mag;
    logic [BcdW-1:0]   bcd;
    logic [InW-1:0]    raw;
    logic              neg;
    logic [WidthW-1:0] width;
  } stage_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib_in);
    logic [3:0] nib;
    nib = nib_in & NibMask;
    if (nib < 4'd10) begin
      return ChZero + CharW'(nib);
    end
    return ChUpA + CharW'(nib) - CharW'(10);
  endfunction

  // eight shift-add-3 steps of the binary to BCD conversion
  function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd_in,
                                                  input logic [StepBits-1:0] bits);
    logic [BcdW-1:0] b;
    b = bcd_in;
    for (int i = 0; i < StepBits; i++) begin
      for (int d = 0; d < DecDigits; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BcdW-2:0], bits[StepBits-1-i]};
    end
    return b;
  endfunction

  function automatic logic bcd_valid(input logic [BcdW-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < DecDigits; d++) begin
      if (bcd[4*d +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

FILE: rtl/core/integer_to_ascii_formatter.sv
// ============================================================================
// integer_to_ascii_formatter
// Path: the input beat is registered in stg_q[0] to stg_q[4] and then in the
//   output shifter. Flow: the single-character output shifter sends a value's
//   1 to 11 characters and takes the next value as its last one is taken; the
//   front pipeline takes a beat every cycle while it has room.
// Reset: asynchronous, active low; clears stage valid bits, the character
//   count and the three mode registers.
// Formats a value as decimal or hex ASCII, one character per output beat,
// through a sign stage, four binary-to-BCD stages and a format/shift stage.
// ============================================================================
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = ifmt_pkg::ValueBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ifmt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ifmt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] value, [35:32] field_width, [39:36] zero
  input  logic [ifmt_pkg::InTdataW-1:0]  s_axis_tdata,
  // [0] is_signed
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [6:0] char_code, [7] zero
  output logic [ifmt_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);
  import ifmt_pkg::*;

  localparam int  EffBits = (VALUE_BITS < InW) ? VALUE_BITS : InW;
  localparam bit  SignOk  = (VALUE_BITS <= InW);
  localparam logic [InW-1:0] ValMask = {InW{1'b1}} >> (InW - EffBits);

  // mode registers
  logic hex_mode_q, show_prefix_q, upper_prefix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_mode_q     <= 1'b0;
      show_prefix_q  <= 1'b0;
      upper_prefix_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgHexMode:     hex_mode_q     <= cfg_data_i[0];
        CfgShowPrefix:  show_prefix_q  <= cfg_data_i[0];
        CfgUpperPrefix: upper_prefix_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front pipeline
  stage_t              stg_q [NumStg];
  stage_t              stg_d [NumStg];
  logic [NumStg-1:0]   vld_q;
  logic [NumStg:0]     rdy;
  logic [CntW-1:0]     rem_q, rem_d;
  logic                ser_take;
  logic                beat;
  logic [InW-1:0]      v_in;
  logic                neg_in;

  assign beat     = m_axis_tvalid && m_axis_tready;
  assign ser_take = (rem_q == '0) || ((rem_q == CntW'(1)) && m_axis_tready);
  assign rdy[NumStg] = ser_take;

  for (genvar k = 0; k < NumStg; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  assign s_axis_tready = rdy[0];

  assign v_in   = s_axis_tdata[InW-1:0] & ValMask;
  assign neg_in = SignOk && s_axis_tuser[0] && v_in[EffBits-1];

  always_comb begin
    stg_d[0].raw   = v_in;
    stg_d[0].neg   = neg_in;
    stg_d[0].width = s_axis_tdata[InW +: WidthW];
    stg_d[0].bcd   = '0;
    stg_d[0].mag   = neg_in ? ((~v_in + InW'(1)) & ValMask) : v_in;
  end

  for (genvar k = 1; k < NumStg; k++) begin : g_dab
    always_comb begin
      stg_d[k]     = stg_q[k-1];
      stg_d[k].bcd = dabble_step(stg_q[k-1].bcd, stg_q[k-1].mag[InW-1 -: StepBits]);
      stg_d[k].mag = stg_q[k-1].mag << StepBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) begin
      stg_q[0] <= stg_d[0];
    end
    for (int k = 1; k < NumStg; k++) begin
      if (rdy[k] && vld_q[k-1]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // format stage
  stage_t              fs;
  logic [3:0]          dig   [DecDigits];
  logic [CharW-1:0]    bchr  [DecDigits];
  logic [CharW-1:0]    nbuf  [MaxChars];
  logic [3:0]          start;
  logic [1:0]          pl;
  logic [CntW-1:0]     len;
  logic [4:0]          idx   [MaxChars];

  assign fs = stg_q[NumStg-1];

  always_comb begin
    for (int j = 0; j < DecDigits; j++) begin
      dig[j] = fs.bcd[4*(DecDigits-1-j) +: 4];
      if (hex_mode_q && (j < HexDigits)) begin
        bchr[j] = hex_char(fs.raw[4*(HexDigits-1-j) +: 4]);
      end else begin
        bchr[j] = ChZero + CharW'(dig[j]);
      end
    end

    if (hex_mode_q) begin
      if ((fs.width != '0) && !fs.width[3]) begin
        start = 4'(HexDigits) - fs.width;
      end else begin
        start = '0;
      end
      pl = show_prefix_q ? 2'd2 : 2'd0;
    end else begin
      if ((fs.width != '0) && (fs.width <= 4'(DecDigits))) begin
        start = 4'(DecDigits) - fs.width;
      end else begin
        start = 4'(DecDigits - 1);
        for (int j = DecDigits - 2; j >= 0; j--) begin
          if (dig[j] != 4'd0) begin
            start = 4'(j);
          end
        end
      end
      pl = fs.neg ? 2'd1 : 2'd0;
    end

    len = CntW'(pl) + (hex_mode_q ? CntW'(HexDigits) : CntW'(DecDigits)) - CntW'(start);

    for (int j = 0; j < MaxChars; j++) begin
      idx[j] = {1'b0, start} + 5'(j) - {3'b000, pl};
      if (5'(j) < {3'b000, pl}) begin
        if (j == 0) begin
          nbuf[j] = hex_mode_q ? ChZero : ChMinus;
        end else begin
          nbuf[j] = upper_prefix_q ? ChUpX : ChLoX;
        end
      end else if (idx[j] < 5'(DecDigits)) begin
        nbuf[j] = bchr[idx[j][3:0]];
      end else begin
        nbuf[j] = ChZero;
      end
    end
  end

  // output shifter
  logic [CharW-1:0] buf_q [MaxChars];
  logic             load;

  assign load = vld_q[NumStg-1] && ser_take;

  always_comb begin
    rem_d = rem_q;
    if (load) begin
      rem_d = len;
    end else if (beat) begin
      rem_d = rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= nbuf;
    end else if (beat) begin
      for (int j = 0; j < MaxChars - 1; j++) begin
        buf_q[j] <= buf_q[j+1];
      end
    end
  end

  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tlast  = (rem_q == CntW'(1));
  assign m_axis_tdata  = {{(OutTdataW - CharW){1'b0}}, buf_q[0]};

  // checks
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= CntW'(MaxChars))
    else $error("character count out of range");

  a_bcd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStg-1] |-> bcd_valid(fs.bcd))
    else $error("invalid BCD digit after conversion");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStg-1] && !ser_take) |=> (vld_q[NumStg-1] && $stable(fs)))
    else $error("stalled format stage changed");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (rem_q != '0))
    else $error("loaded item produced no characters");

endmodule

FILE: tb/sv/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// integer_to_ascii_formatter_tb
// Self-checking bench for the integer to ASCII formatter. A directed table of
// extremes and width/sign corner cases is followed by random values in eight
// phases that step through every mode setting. The phases rotate through four
// mixes of sender gaps and receiver stalls. Every output character beat is
// checked against its table text or a behavioural predictor of the formatter.
// ============================================================================
module integer_to_ascii_formatter_tb;
  import ifmt_pkg::*;

  localparam int WatchdogCycles = 2000;
  localparam int RandPerPhase   = 40;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } out_char_t;

  typedef struct {
    logic [31:0] val;
    logic        sgn;
    logic [3:0]  fw;
    logic        hex;
    logic        pfx;
    logic        upr;
    string       text;  // empty: take the predictor's answer
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = CfgHexMode;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // shadow of the mode registers
  logic hex_mode_q     = 1'b0;
  logic show_prefix_q  = 1'b0;
  logic upper_prefix_q = 1'b0;

  out_char_t pending_chars[$];
  int        errors         = 0;
  int        src_idle_pct   = 0;
  int        sink_stall_pct = 0;
  int        quiet_cycles   = 0;

  dir_row_t dir_rows [25] = '{
    '{32'h0000_0000, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0, "0"},
    '{32'hFFFF_FFFF, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0, "4294967295"},
    '{32'hFFFF_FFFF, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0, "-1"},
    '{32'h8000_0000, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0, "-2147483648"},
    '{32'h7FFF_FFFF, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0, "2147483647"},
    '{32'h8000_0000, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0, "2147483648"},
    '{32'd123,       1'b0, 4'd5,  1'b0, 1'b0, 1'b0, "00123"},
    '{32'd123456,    1'b0, 4'd3,  1'b0, 1'b0, 1'b0, ""},
    '{32'hFFED_2979, 1'b1, 4'd3,  1'b0, 1'b0, 1'b0, "-567"},
    '{32'd42,        1'b0, 4'd10, 1'b0, 1'b0, 1'b0, "0000000042"},
    '{32'd42,        1'b0, 4'd11, 1'b0, 1'b0, 1'b0, "42"},
    '{32'h0000_0000, 1'b1, 4'd15, 1'b0, 1'b0, 1'b0, "0"},
    '{32'd1000000000, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, "1000000000"},
    '{32'hDEAD_BEEF, 1'b0, 4'd0,  1'b1, 1'b0, 1'b0, "DEADBEEF"},
    '{32'hDEAD_BEEF, 1'b0, 4'd4,  1'b1, 1'b0, 1'b0, "BEEF"},
    '{32'h1234_5678, 1'b0, 4'd1,  1'b1, 1'b0, 1'b0, "8"},
    '{32'h1234_5678, 1'b0, 4'd7,  1'b1, 1'b0, 1'b0, "2345678"},
    '{32'hFFFF_FFFF, 1'b1, 4'd8,  1'b1, 1'b0, 1'b0, "FFFFFFFF"},
    '{32'h0000_0000, 1'b0, 4'd15, 1'b1, 1'b0, 1'b0, "00000000"},
    '{32'h0000_00A5, 1'b0, 4'd2,  1'b1, 1'b1, 1'b0, "0xA5"},
    '{32'h0000_0000, 1'b0, 4'd0,  1'b1, 1'b1, 1'b0, "0x00000000"},
    '{32'hCAFE_F00D, 1'b1, 4'd0,  1'b1, 1'b1, 1'b1, "0XCAFEF00D"},
    '{32'h0000_0009, 1'b0, 4'd1,  1'b1, 1'b1, 1'b1, "0X9"},
    '{32'h89AB_CDEF, 1'b0, 4'd6,  1'b1, 1'b1, 1'b1, ""},
    '{32'h8000_0000, 1'b1, 4'd10, 1'b0, 1'b1, 1'b1, "-2147483648"}
  };

  integer_to_ascii_formatter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 100) begin
      $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    end
    errors++;
  endtask

  function automatic void queue_chars(ref logic [CharW-1:0] chars[$]);
    for (int i = 0; i < chars.size(); i++) begin
      pending_chars.push_back('{chars[i], i == chars.size() - 1});
    end
  endfunction

  function automatic void queue_text(input string s);
    logic [CharW-1:0] chars[$];
    byte              b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      chars.push_back(b[CharW-1:0]);
    end
    queue_chars(chars);
  endfunction

  // characters the formatter should emit for one value under the current mode
  function automatic void predict_chars(input logic [31:0] val, input logic sgn,
                                        input logic [3:0] fw);
    logic [CharW-1:0] chars[$];
    logic [31:0]      mag;
    logic [3:0]       dig [DecDigits];
    logic [3:0]       nib;
    int               cnt;
    int               first;
    if (hex_mode_q) begin
      if (show_prefix_q) begin
        chars.push_back(ChZero);
        chars.push_back(upper_prefix_q ? ChUpX : ChLoX);
      end
      cnt = (fw >= 4'd1 && fw <= 4'd7) ? int'(fw) : HexDigits;
      for (int k = cnt; k > 0; k--) begin
        nib = val[4*(k-1) +: 4];
        chars.push_back(nib < 4'd10 ? ChZero + CharW'(nib) : ChUpA + CharW'(nib) - CharW'(10));
      end
    end else begin
      mag = val;
      if (sgn && val[31]) begin
        chars.push_back(ChMinus);
        mag = -val;
      end
      for (int d = DecDigits - 1; d >= 0; d--) begin
        dig[d] = 4'(mag % 10);
        mag    = mag / 10;
      end
      if (fw >= 4'd1 && fw <= 4'd10) begin
        first = DecDigits - int'(fw);
      end else begin
        first = 0;
        while (first < DecDigits - 1 && dig[first] == 4'd0) first++;
      end
      for (int d = first; d < DecDigits; d++) begin
        chars.push_back(ChZero + CharW'(dig[d]));
      end
    end
    queue_chars(chars);
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] p;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20);
      2: return $urandom >> $urandom_range(0, 31);
      3: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      4: return -($urandom >> $urandom_range(0, 31));
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          default: return 32'h8000_0001;
        endcase
      end
    endcase
  endfunction

  // all three mode registers, one per cycle; block must be idle
  task automatic program_format(input logic hex, input logic pfx, input logic upr);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgHexMode;
    cfg_data_i <= hex;
    @(posedge clk_i);
    cfg_idx_i  <= CfgShowPrefix;
    cfg_data_i <= pfx;
    @(posedge clk_i);
    cfg_idx_i  <= CfgUpperPrefix;
    cfg_data_i <= upr;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    hex_mode_q     = hex;
    show_prefix_q  = pfx;
    upper_prefix_q = upr;
  endtask

  task automatic send_value(input logic [31:0] val, input logic sgn, input logic [3:0] fw);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'({fw, val});
    s_axis_tuser  <= sgn;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_chars();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // output side: check each beat, then pick next cycle's ready
  always @(posedge clk_i) begin
    out_char_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected char", m_axis_tdata[CharW-1:0], 0);
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata[CharW-1:0] !== want.code) begin
          report_mismatch("char_code", m_axis_tdata[CharW-1:0], want.code);
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last_char", m_axis_tlast, want.last);
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogCycles) begin
      $display("integer_to_ascii_formatter_tb failed");
      $finish;
    end
  end

  initial begin
    dir_row_t    row;
    logic [31:0] val;
    logic        sgn;
    logic [3:0]  fw;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.hex != hex_mode_q || row.pfx != show_prefix_q || row.upr != upper_prefix_q) begin
        drain_chars();
        program_format(row.hex, row.pfx, row.upr);
      end
      send_value(row.val, row.sgn, row.fw);
      if (row.text.len() != 0) begin
        queue_text(row.text);
      end else begin
        predict_chars(row.val, row.sgn, row.fw);
      end
    end

    // random phases: every mode setting, rotating through the idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      drain_chars();
      program_format(ph[0], ph[1], ph[2]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        if (ph == 5 && n == RandPerPhase / 2) begin
          drain_chars();
        end
        val = rand_value();
        sgn = 1'($urandom_range(0, 1));
        fw  = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
        send_value(val, sgn, fw);
        predict_chars(val, sgn, fw);
      end
    end

    drain_chars();
    if (errors == 0) begin
      $display("integer_to_ascii_formatter_tb passed");
    end else begin
      $display("integer_to_ascii_formatter_tb failed");
    end
    $finish;
  end

endmodule
